// File: design/hdg_pkg.sv
// Shared types, widths and the arctangent table for the heading pipeline.
// Depends on nothing; used by every module in this folder.
package hdg_pkg;

    localparam int ANGLE_STEPS = 16;
    localparam int TBL_LEN     = 24;
    localparam int TBL_IDX_W   = $clog2(TBL_LEN);

    localparam int FIELD_W = 16;
    localparam int PRE_SH  = 16;
    localparam int XY_W    = 36;
    localparam int Z_W     = 27;
    localparam int OUT_W   = 15;
    localparam int RND_SH  = 10;

    localparam int IN_TDATA_W  = 2 * FIELD_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic signed [Z_W-1:0] DEG_180 = Z_W'(180 * 65536);
    localparam logic signed [Z_W-1:0] DEG_360 = Z_W'(360 * 65536);
    localparam logic [Z_W-1:0]        RND_HALF = Z_W'(1 << (RND_SH - 1));
    localparam logic [OUT_W:0]        OUT_FULL_TURN = (OUT_W + 1)'(23040);

    typedef logic signed [XY_W-1:0] xy_t;
    typedef logic signed [Z_W-1:0]  ang_t;

    typedef struct packed {
        xy_t        x;
        xy_t        y;
        ang_t       z;
        logic       zero;
    } hdg_data_t;

    function automatic ang_t atan_q16(input logic [TBL_IDX_W-1:0] idx);
        ang_t r;
        case (idx)
            5'd0:    r = Z_W'(2949120);
            5'd1:    r = Z_W'(1740967);
            5'd2:    r = Z_W'(919879);
            5'd3:    r = Z_W'(466945);
            5'd4:    r = Z_W'(234379);
            5'd5:    r = Z_W'(117304);
            5'd6:    r = Z_W'(58666);
            5'd7:    r = Z_W'(29335);
            5'd8:    r = Z_W'(14668);
            5'd9:    r = Z_W'(7334);
            5'd10:   r = Z_W'(3667);
            5'd11:   r = Z_W'(1833);
            5'd12:   r = Z_W'(917);
            5'd13:   r = Z_W'(458);
            5'd14:   r = Z_W'(229);
            5'd15:   r = Z_W'(115);
            5'd16:   r = Z_W'(57);
            5'd17:   r = Z_W'(29);
            5'd18:   r = Z_W'(14);
            5'd19:   r = Z_W'(7);
            5'd20:   r = Z_W'(4);
            5'd21:   r = Z_W'(2);
            5'd22:   r = Z_W'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: design/hdg_prep.sv
// Entry stage: scales the raw field counts, folds the left half plane and
// flags the zero vector. Depends on hdg_pkg.
module hdg_prep (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [hdg_pkg::FIELD_W-1:0] field_x,
    input  logic signed [hdg_pkg::FIELD_W-1:0] field_y,
    output logic                               out_valid,
    input  logic                               out_ready,
    output hdg_pkg::hdg_data_t                 out_data
);
    import hdg_pkg::*;

    logic      valid_reg;
    hdg_data_t data_reg;
    hdg_data_t data_next;
    xy_t       x_wide;
    xy_t       y_wide;

    assign x_wide = xy_t'($signed({field_x, {PRE_SH{1'b0}}}));
    assign y_wide = xy_t'($signed({field_y, {PRE_SH{1'b0}}}));

    always_comb
    begin
        data_next.zero = (field_x == '0) && (field_y == '0);
        if (field_x[FIELD_W-1])
        begin
            data_next.x = -x_wide;
            data_next.y = -y_wide;
            data_next.z = DEG_180;
        end
        else
        begin
            data_next.x = x_wide;
            data_next.y = y_wide;
            data_next.z = '0;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

// File: design/hdg_stage.sv
// One registered CORDIC vectoring micro-rotation; the step index is tied
// to a constant at each instance. Depends on hdg_pkg.
module hdg_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [hdg_pkg::TBL_IDX_W-1:0]   step,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  hdg_pkg::hdg_data_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output hdg_pkg::hdg_data_t              out_data
);
    import hdg_pkg::*;

    logic      valid_reg;
    hdg_data_t data_reg;
    hdg_data_t data_next;
    xy_t       xs;
    xy_t       ys;
    ang_t      da;

    assign xs = in_data.x >>> step;
    assign ys = in_data.y >>> step;
    assign da = atan_q16(step);

    always_comb
    begin
        data_next.zero = in_data.zero;
        if (!in_data.y[XY_W-1])
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + da;
        end
        else
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - da;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

// File: design/hdg_post.sv
// Exit stage: wraps the angle into one turn, rounds to 1/64 degree and
// holds the result for the output channel. Depends on hdg_pkg.
module hdg_post (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  hdg_pkg::hdg_data_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [hdg_pkg::OUT_W-1:0]        heading_deg
);
    import hdg_pkg::*;

    logic             valid_reg;
    logic [OUT_W-1:0] heading_reg;
    logic [OUT_W-1:0] heading_next;
    ang_t             z_wrap;
    logic [Z_W-1:0]   z_rnd;
    logic [OUT_W:0]   h;

    always_comb
    begin
        z_wrap = in_data.z;
        if (z_wrap[Z_W-1])
            z_wrap = z_wrap + DEG_360;
        else if (z_wrap >= DEG_360)
            z_wrap = z_wrap - DEG_360;
        z_rnd = Z_W'(z_wrap) + RND_HALF;
        h     = z_rnd[RND_SH +: OUT_W + 1];
        if (h >= OUT_FULL_TURN)
            h = h - OUT_FULL_TURN;
        heading_next = in_data.zero ? '0 : h[OUT_W-1:0];
    end

    assign in_ready    = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign heading_deg = heading_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            heading_reg <= heading_next;
    end

endmodule

// File: design/compass_heading_atan2.sv
// Compass heading top level: entry stage, CORDIC rotation stages, exit stage.
// Depends on hdg_pkg, hdg_prep, hdg_stage and hdg_post.
//
// Usage:
//   The slave channel takes one magnetometer sample per transfer; s_tdata
//   holds field_x in bits 15:0 and field_y in bits 31:16, both signed.
//   The master channel gives one heading per sample, in sample order, as
//   unsigned degrees with 6 fraction bits (0 to 23039) in m_tdata[14:0].
//   A sample passes the entry register, which loads at the accepting
//   edge, then one register per micro-rotation and the exit register,
//   before m_tvalid rises. Throughput is one sample per cycle while
//   m_tready is high; every stage holds its own valid bit and its own
//   ready, so bubbles close up while the receiver stalls.
//   With m_tready low, the held result stays on m_tdata and upstream
//   stages keep accepting until every stage is full; no transfer is lost
//   or repeated. A zero vector gives heading 0.
//   Reset clears every valid bit, so the block is ready to take a
//   sample once rst_n rises.
module compass_heading_atan2 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // field_x [15:0], field_y [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // heading_deg [14:0]
);
    import hdg_pkg::*;

    hdg_data_t        stg_data  [0:ANGLE_STEPS];
    logic             stg_valid [0:ANGLE_STEPS];
    logic             stg_ready [0:ANGLE_STEPS];
    logic [OUT_W-1:0] heading_deg;

    hdg_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .field_x   (s_tdata[FIELD_W-1:0]),
        .field_y   (s_tdata[IN_TDATA_W-1:FIELD_W]),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    for (genvar i = 0; i < ANGLE_STEPS; i++)
    begin : g_step
        hdg_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (TBL_IDX_W'(i)),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    hdg_post u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (stg_valid[ANGLE_STEPS]),
        .in_ready    (stg_ready[ANGLE_STEPS]),
        .in_data     (stg_data[ANGLE_STEPS]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .heading_deg (heading_deg)
    );

    assign m_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}}, heading_deg};

`ifndef SYNTHESIS
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[OUT_W-1:0]} < OUT_FULL_TURN))
        else $error("heading outside one turn");

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage is empty");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");
`endif

endmodule
